@@ hw/rtl/arc_pkg.sv @@
`timescale 1ns / 1ps
package arc_pkg;
  localparam int COLOR_BITS = 16;
  localparam int MUL_A = 20;
  localparam int MUL_B = 17;
  localparam int MUL_P = MUL_A + MUL_B;
  localparam int DIV_N = 16;
  localparam logic [19:0] ENV_MAX = 20'hFFFFF;
  localparam logic [16:0] BEAT_RISE = 17'd6554;
  localparam logic [16:0] ONE_Q16 = 17'h10000;
  localparam logic [2:0] REG_BAND = 3'd0;
  localparam logic [2:0] REG_BGAIN = 3'd1;
  localparam logic [2:0] REG_HSTEP = 3'd2;
  localparam logic [2:0] REG_ATT = 3'd3;
  localparam logic [2:0] REG_REL = 3'd4;
  localparam logic [2:0] REG_SENS = 3'd5;
  localparam logic [2:0] REG_HSM = 3'd6;
  localparam logic [2:0] REG_HOLD = 3'd7;

  function automatic logic [16:0] sat_coeff(input logic [16:0] k);
    sat_coeff = (k > ONE_Q16) ? ONE_Q16 : k;
  endfunction
endpackage

@@ hw/rtl/arc_mul.sv @@
`timescale 1ns / 1ps
// Shift-add multiplier: one multiplier bit per cycle.
module arc_mul (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [arc_pkg::MUL_A-1:0]    a,
  input  logic [arc_pkg::MUL_B-1:0]    b,
  output logic                         done,
  output logic [arc_pkg::MUL_P-1:0]    p
);
  logic [arc_pkg::MUL_P-1:0] acc;
  logic [arc_pkg::MUL_P-1:0] mcand;
  logic [arc_pkg::MUL_B-1:0] mplier;
  logic [4:0] cnt;
  logic busy;

  assign p = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= 5'(arc_pkg::MUL_B);
        acc <= '0;
        mcand <= arc_pkg::MUL_P'(a);
        mplier <= b;
      end else if (busy) begin
        if (mplier[0]) acc <= acc + mcand;
        mcand <= mcand << 1;
        mplier <= mplier >> 1;
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

@@ hw/rtl/arc_div.sv @@
`timescale 1ns / 1ps
// Restoring divider: q = floor(n*65536 / den), n < den, one quotient bit a cycle.
module arc_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [18:0] num,
  input  logic [18:0] den,
  output logic        done,
  output logic [15:0] q
);
  logic [19:0] rem;
  logic [18:0] d;
  logic [4:0] cnt;
  logic busy;
  logic [20:0] sh;

  assign sh = {rem, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem <= {1'b0, num};
        d <= den;
        q <= '0;
        cnt <= 5'(arc_pkg::DIV_N);
      end else if (busy) begin
        if (sh >= {2'b0, d}) begin
          rem <= 20'(sh - {2'b0, d});
          q <= {q[14:0], 1'b1};
        end else begin
          rem <= sh[19:0];
          q <= {q[14:0], 1'b0};
        end
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

@@ hw/rtl/audio_reactive_color_core.sv @@
`timescale 1ns / 1ps
// One tick per input beat. A sequencer feeds a bit-serial multiplier and a
// bit-serial hue divider. With hue rotation on there are 11 products and one
// division; with rotation off there are 9 products. A gray color skips the
// divider and the product after it. The result waits in an output register
// until it is taken. The next input is taken once that register is free.
// Configuration is written through a plain write port; the user must write
// it only while idle, since the block itself does not enforce this.
module audio_reactive_color_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [16:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] bass_level,
  input  logic [15:0] mid_level,
  input  logic [15:0] treble_level,
  input  logic [15:0] beat_level,
  input  logic [15:0] color_red,
  input  logic [15:0] color_green,
  input  logic [15:0] color_blue,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_red,
  output logic [15:0] out_green,
  output logic [15:0] out_blue,
  output logic [15:0] brightness_level,
  output logic        beat_taken
);
  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_MIXA  = 10'b0000000010,
    S_MIXB  = 10'b0000000100,
    S_SENS  = 10'b0000001000,
    S_BEAT  = 10'b0000010000,
    S_ENV   = 10'b0000100000,
    S_HUE   = 10'b0001000000,
    S_DIV   = 10'b0010000000,
    S_FD    = 10'b0100000000,
    S_SCALE = 10'b1000000000
  } state_t;

  state_t state;
  logic [9:0]  band_select, beat_gain;
  logic [15:0] hue_step, sensitivity;
  logic [16:0] attack_coeff, release_coeff, hue_smooth_coeff;
  logic [7:0]  holdoff_ticks;
  logic [19:0] envelope;
  logic [15:0] hue_target, hue_visible, previous_beat;
  logic [7:0]  ticks_since_step;

  logic [15:0] b1, beat, cr, cg, cb;
  logic [8:0]  frac;
  logic [24:0] acc;
  logic [24:0] drive;
  logic        up, hneg;
  logic [15:0] mx, mn, dd;
  logic [18:0] nn;
  logic [15:0] col [3];
  logic [1:0]  ch;

  logic        m_start, m_done, d_start, d_done;
  logic [arc_pkg::MUL_A-1:0] m_a;
  logic [arc_pkg::MUL_B-1:0] m_b;
  logic [arc_pkg::MUL_P-1:0] m_p;
  logic [15:0] d_q;

  arc_mul u_mul (.clk(clk), .rst(rst), .start(m_start), .a(m_a), .b(m_b),
                 .done(m_done), .p(m_p));
  arc_div u_div (.clk(clk), .rst(rst), .start(d_start), .num(nn),
                 .den(19'(dd) * 19'd6), .done(d_done), .q(d_q));

  assign in_ready = !rst && (state == S_IDLE) && !out_valid;

  logic [9:0]  sel;
  logic [8:0]  fsel;
  logic [16:0] tk;
  logic        hit;
  logic [15:0] hnew;
  logic [18:0] hx;
  logic [15:0] qv, uv;
  logic [16:0] gain;
  logic [15:0] cmask;

  always_comb begin
    sel = (band_select > 10'd512) ? 10'd512 : band_select;
    fsel = (sel < 10'd256) ? sel[8:0] : 9'(sel - 10'd256);
    tk = (ticks_since_step < 8'd255) ? 17'(ticks_since_step) + 17'd1 : 17'd255;
    hit = ({1'b0, beat_level} > 17'(previous_beat) + arc_pkg::BEAT_RISE) &&
          ((tk > 17'(holdoff_ticks)) || (tk == 17'd255));
    hnew = 16'(d_q + hue_visible);
    hx = 19'(hnew) * 19'd6;
    qv = 16'(mx - m_p[31:16]);
    uv = 16'(mn + m_p[31:16]);
    gain = (envelope > 20'(arc_pkg::ONE_Q16)) ? arc_pkg::ONE_Q16 : envelope[16:0];
    cmask = 16'((17'h0FFFF >> (16 - arc_pkg::COLOR_BITS)) << (16 - arc_pkg::COLOR_BITS));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      m_start <= 1'b0;
      d_start <= 1'b0;
      band_select <= '0; beat_gain <= '0; hue_step <= '0;
      attack_coeff <= 17'd65536; release_coeff <= 17'd4096;
      sensitivity <= 16'd256; hue_smooth_coeff <= 17'd16384;
      holdoff_ticks <= 8'd25;
      envelope <= '0; hue_target <= '0; hue_visible <= '0;
      previous_beat <= '0; ticks_since_step <= '0;
    end else begin
      m_start <= 1'b0;
      d_start <= 1'b0;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          arc_pkg::REG_BAND:  band_select <= cfg_data[9:0];
          arc_pkg::REG_BGAIN: beat_gain <= cfg_data[9:0];
          arc_pkg::REG_HSTEP: hue_step <= cfg_data[15:0];
          arc_pkg::REG_ATT:   attack_coeff <= cfg_data;
          arc_pkg::REG_REL:   release_coeff <= cfg_data;
          arc_pkg::REG_SENS:  sensitivity <= cfg_data[15:0];
          arc_pkg::REG_HSM:   hue_smooth_coeff <= cfg_data;
          arc_pkg::REG_HOLD:  holdoff_ticks <= cfg_data[7:0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: if (in_valid && in_ready) begin
          b1 <= (sel < 10'd256) ? mid_level : treble_level;
          frac <= fsel;
          beat <= beat_level;
          cr <= color_red; cg <= color_green; cb <= color_blue;
          previous_beat <= beat_level;
          if (hit) begin
            hue_target <= 16'(hue_target + hue_step);
            ticks_since_step <= '0;
          end else ticks_since_step <= tk[7:0];
          beat_taken <= hit;
          m_a <= 20'((sel < 10'd256) ? bass_level : mid_level);
          m_b <= 17'(9'd256 - fsel);
          m_start <= 1'b1;
          state <= S_MIXA;
        end
        S_MIXA: if (m_done) begin
          acc <= m_p[24:0];
          m_a <= 20'(b1); m_b <= 17'(frac); m_start <= 1'b1;
          state <= S_MIXB;
        end
        S_MIXB: if (m_done) begin
          m_a <= 20'(25'(acc + m_p[24:0]) >> 8);
          m_b <= 17'(sensitivity); m_start <= 1'b1;
          state <= S_SENS;
        end
        S_SENS: if (m_done) begin
          drive <= m_p[31:7];
          m_a <= 20'(beat); m_b <= 17'(beat_gain); m_start <= 1'b1;
          state <= S_BEAT;
        end
        S_BEAT: if (m_done) begin : beat_done
          logic [25:0] dsum;
          logic [19:0] dv;
          dsum = 26'(drive) + 26'(m_p[25:8]);
          dv = (dsum > 26'(arc_pkg::ENV_MAX)) ? arc_pkg::ENV_MAX : dsum[19:0];
          drive <= 25'(dv);
          up <= dv > envelope;
          m_a <= (dv > envelope) ? 20'(dv - envelope) : 20'(envelope - dv);
          m_b <= arc_pkg::sat_coeff((dv > envelope) ? attack_coeff : release_coeff);
          m_start <= 1'b1;
          state <= S_ENV;
        end
        S_ENV: if (m_done) begin : env_done
          logic [15:0] diff;
          envelope <= up ? 20'(envelope + m_p[35:16]) : 20'(envelope - m_p[35:16]);
          diff = 16'(hue_target - hue_visible);
          hneg <= diff[15];
          if (hue_step != 16'd0) begin
            m_a <= diff[15] ? 20'(17'h10000 - 17'(diff)) : 20'(diff);
            m_b <= arc_pkg::sat_coeff(hue_smooth_coeff);
            m_start <= 1'b1;
            state <= S_HUE;
          end else begin
            col[0] <= cr; col[1] <= cg; col[2] <= cb;
            ch <= 2'd3;
            state <= S_SCALE;
            m_start <= 1'b1;
            m_a <= 20'(cr);
            m_b <= 17'(0);
          end
        end
        S_HUE: if (m_done) begin : hue_done
          logic [15:0] r, g, bl, xm, xn, d;
          logic signed [19:0] n;
          hue_visible <= hneg ? 16'(hue_visible - m_p[31:16]) :
                                16'(hue_visible + m_p[31:16]);
          r = cr; g = cg; bl = cb;
          xm = r; xn = r;
          if (g > xm) xm = g;
          if (bl > xm) xm = bl;
          if (g < xn) xn = g;
          if (bl < xn) xn = bl;
          d = 16'(xm - xn);
          if (xm == r) n = 20'(signed'({4'b0, g})) - 20'(signed'({4'b0, bl}));
          else if (xm == g) n = 20'(signed'({3'b0, d, 1'b0})) +
                                20'(signed'({4'b0, bl})) - 20'(signed'({4'b0, r}));
          else n = 20'(signed'({2'b0, d, 2'b0})) +
                   20'(signed'({4'b0, r})) - 20'(signed'({4'b0, g}));
          if (n < 0) n = n + 20'(signed'({1'b0, 19'(d) * 19'd6}));
          mx <= xm; mn <= xn; dd <= d;
          nn <= 19'(n);
          if (d == 16'd0) begin
            col[0] <= cr; col[1] <= cg; col[2] <= cb;
            ch <= 2'd3; m_a <= 20'(cr); m_b <= 17'(0); m_start <= 1'b1;
            state <= S_SCALE;
          end else begin
            d_start <= 1'b1;
            state <= S_DIV;
          end
        end
        S_DIV: if (d_done) begin
          m_a <= 20'(hx[15:0]); m_b <= 17'(dd); m_start <= 1'b1;
          frac <= {6'b0, hx[18:16]};
          state <= S_FD;
        end
        S_FD: if (m_done) begin
          case (frac[2:0])
            3'd0: begin col[0] <= mx; col[1] <= uv; col[2] <= mn; end
            3'd1: begin col[0] <= qv; col[1] <= mx; col[2] <= mn; end
            3'd2: begin col[0] <= mn; col[1] <= mx; col[2] <= uv; end
            3'd3: begin col[0] <= mn; col[1] <= qv; col[2] <= mx; end
            3'd4: begin col[0] <= uv; col[1] <= mn; col[2] <= mx; end
            default: begin col[0] <= mx; col[1] <= mn; col[2] <= qv; end
          endcase
          ch <= 2'd3; m_b <= 17'(0); m_start <= 1'b1;
          state <= S_SCALE;
        end
        S_SCALE: begin
          // first pass is a dummy product that lets col settle
          if (m_done) begin
            if (ch == 2'd3) begin
              m_a <= 20'(col[0]);
              m_b <= gain;
              m_start <= 1'b1;
              ch <= 2'd0;
            end else begin
              col[ch] <= m_p[31:16] & cmask;
              if (ch == 2'd2) begin
                out_valid <= 1'b1;
                state <= S_IDLE;
              end else begin
                m_a <= 20'(col[2'(ch + 2'd1)]);
                m_b <= gain;
                m_start <= 1'b1;
                ch <= ch + 2'd1;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    out_red = col[0];
    out_green = col[1];
    out_blue = col[2];
    brightness_level = (envelope > 20'hFFFF) ? 16'hFFFF : envelope[15:0];
  end
endmodule
